>>> rtl/core/voxel_dose_energy_scoring_assert.svh
// Assertion macros used by the voxel scoring checker
`ifndef VOXEL_DOSE_ENERGY_SCORING_ASSERT_SVH
`define VOXEL_DOSE_ENERGY_SCORING_ASSERT_SVH

// Same-cycle implication, clocked on aclk
`define VDES_ASSERT_NOW(lbl, rst, a, c) \
    lbl: assert property (@(posedge aclk) disable iff (rst) (a) |-> (c)) \
        else $error("voxel scoring check failed");

// Next-cycle implication, clocked on aclk
`define VDES_ASSERT_NEXT(lbl, rst, a, c) \
    lbl: assert property (@(posedge aclk) disable iff (rst) (a) |=> (c)) \
        else $error("voxel scoring check failed");

`endif

>>> rtl/core/vdes_pkg.sv
// Shared types and constants of the voxel dose and energy scoring block
`default_nettype none
package vdes_pkg;

    localparam int NUM_VOXELS_DEF = 65536;
    localparam int ACC_WIDTH_DEF  = 48;

    localparam int S_TDATA_W   = 216;
    localparam int M_TDATA_W   = 112;
    localparam int OUT_W       = 48;
    localparam int OUT_IDX_W   = 16;
    localparam int PROD_W      = 56;
    localparam int DEN_W       = 44;
    localparam int IDX_MAX_W   = 24;
    localparam int FRAC_BITS   = 24;
    localparam int DIV_STEPS   = PROD_W + FRAC_BITS;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_IDX_W   = 3;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_VOXEL_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_VOXEL_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_VOXEL_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_DIMS  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SCORE_MODE = 3'd7;

    // Function codes on s_tuser
    localparam logic FUNC_DEPOSIT = 1'b0;
    localparam logic FUNC_READ    = 1'b1;

    typedef struct packed {
        logic [31:0] offset_x;
        logic [31:0] offset_y;
        logic [31:0] offset_z;
        logic [31:0] inv_voxel_x;
        logic [31:0] inv_voxel_y;
        logic [31:0] inv_voxel_z;
        logic [29:0] grid_dims;
        logic [1:0]  score_mode;
    } cfg_t;

    // One classified item between the front and the back
    typedef struct packed {
        logic                 is_read;
        logic                 hit;
        logic                 esc;
        logic [IDX_MAX_W-1:0] idx;
        logic [PROD_W-1:0]    prod;
        logic [DEN_W-1:0]     den;
    } item_t;

    // Queue handshake toward its reader
    typedef struct packed {
        logic  empty;
        item_t head;
    } q_rd_t;

endpackage
`default_nettype wire

>>> rtl/core/vdes_front.sv
// Front end: accept items, locate the voxel, form the sample operands
`default_nettype none
module vdes_front #(
    parameter int NUM_VOXELS = vdes_pkg::NUM_VOXELS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire vdes_pkg::cfg_t                 cfg,
    input  wire logic                           clr_busy,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [vdes_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                           s_tuser,
    output logic                                q_push,
    output vdes_pkg::item_t                     q_item,
    input  wire logic                           q_full
);

    typedef enum logic [2:0] {F_IDLE, F_AX, F_IDX, F_MUL, F_CHK, F_PUSH} state_t;

    state_t      state_reg;
    logic [1:0]  ax_reg;
    logic [31:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic [23:0] mult_reg, dens_reg;
    logic [31:0] de_reg;
    logic [19:0] spr_reg;
    logic        rej_reg;
    logic [31:0] sx_hi_reg, sy_hi_reg, sz_hi_reg;
    logic        sx_frac_reg;
    logic [9:0]  ix_reg, iy_reg;
    logic [19:0] t1_reg;
    logic [30:0] t2_reg;
    vdes_pkg::item_t item_reg;

    logic [31:0] pos_sel, off_sel, inv_sel;
    logic [32:0] d;
    logic [63:0] sprod;
    logic [9:0]  nx, ny, nz;
    logic [32:0] cx;
    logic        rej_idx;
    logic [31:0] flat;

    assign nx = cfg.grid_dims[9:0];
    assign ny = cfg.grid_dims[19:10];
    assign nz = cfg.grid_dims[29:20];

    assign s_tready = (state_reg == F_IDLE) && !clr_busy;
    assign q_push   = (state_reg == F_PUSH) && !q_full;
    assign q_item   = item_reg;

    // Select the axis handled this cycle and scale its distance
    always_comb begin
        case (ax_reg)
            2'd0: begin
                pos_sel = pos_x_reg; off_sel = cfg.offset_x; inv_sel = cfg.inv_voxel_x;
            end
            2'd1: begin
                pos_sel = pos_y_reg; off_sel = cfg.offset_y; inv_sel = cfg.inv_voxel_y;
            end
            default: begin
                pos_sel = pos_z_reg; off_sel = cfg.offset_z; inv_sel = cfg.inv_voxel_z;
            end
        endcase
        d     = {pos_sel[31], pos_sel} - {off_sel[31], off_sel};
        sprod = d[31:0] * inv_sel;
    end

    // Column on x is mirrored: take the ceiling and count from the far end
    always_comb begin
        cx      = {1'b0, sx_hi_reg} + 33'(sx_frac_reg);
        rej_idx = (cx == 33'd0) || (cx > 33'(nx)) ||
                  (sy_hi_reg >= 32'(ny)) || (sz_hi_reg >= 32'(nz));
        flat    = 32'(ix_reg) + 32'(t2_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            ax_reg    <= 2'd0;
        end else begin
            case (state_reg)
                F_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        pos_x_reg <= s_tdata[31:0];
                        pos_y_reg <= s_tdata[63:32];
                        pos_z_reg <= s_tdata[95:64];
                        mult_reg  <= s_tdata[119:96];
                        de_reg    <= s_tdata[151:120];
                        dens_reg  <= s_tdata[175:152];
                        spr_reg   <= s_tdata[195:176];
                        rej_reg   <= 1'b0;
                        ax_reg    <= 2'd0;
                        item_reg.esc     <= cfg.score_mode[1];
                        item_reg.is_read <= (s_tuser == vdes_pkg::FUNC_READ);
                        item_reg.prod    <= '0;
                        item_reg.den     <= '0;
                        if (s_tuser == vdes_pkg::FUNC_READ) begin
                            item_reg.hit <= 32'(s_tdata[211:196]) < 32'(NUM_VOXELS);
                            item_reg.idx <= vdes_pkg::IDX_MAX_W'(s_tdata[211:196]);
                            state_reg    <= F_PUSH;
                        end else begin
                            state_reg <= F_AX;
                        end
                    end
                end
                F_AX: begin
                    rej_reg <= rej_reg | d[32];
                    case (ax_reg)
                        2'd0: begin
                            sx_hi_reg     <= sprod[63:32];
                            sx_frac_reg   <= |sprod[31:0];
                            item_reg.prod <= mult_reg * de_reg;
                        end
                        2'd1: begin
                            sy_hi_reg    <= sprod[63:32];
                            item_reg.den <= cfg.score_mode[0] ?
                                            vdes_pkg::DEN_W'({spr_reg, 16'd0}) :
                                            dens_reg * spr_reg;
                        end
                        default: sz_hi_reg <= sprod[63:32];
                    endcase
                    ax_reg <= ax_reg + 2'd1;
                    if (ax_reg == 2'd2) state_reg <= F_IDX;
                end
                F_IDX: begin
                    rej_reg   <= rej_reg | rej_idx;
                    ix_reg    <= nx - cx[9:0];
                    iy_reg    <= sy_hi_reg[9:0];
                    t1_reg    <= ny * sz_hi_reg[9:0];
                    state_reg <= F_MUL;
                end
                F_MUL: begin
                    t2_reg    <= nx * (21'(iy_reg) + 21'(t1_reg));
                    state_reg <= F_CHK;
                end
                F_CHK: begin
                    item_reg.hit <= !rej_reg && (flat < 32'(NUM_VOXELS));
                    item_reg.idx <= flat[vdes_pkg::IDX_MAX_W-1:0];
                    state_reg    <= F_PUSH;
                end
                F_PUSH: begin
                    if (!q_full) state_reg <= F_IDLE;
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/vdes_queue.sv
// Short item queue between the front and the back
`default_nettype none
module vdes_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire vdes_pkg::item_t push_item,
    output logic                 full,
    input  wire logic            pop,
    output vdes_pkg::q_rd_t      rd
);

    localparam int DEPTH = vdes_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);

    vdes_pkg::item_t      slot_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]       count_reg;

    assign full     = (count_reg == (PTR_W+1)'(DEPTH));
    assign rd.empty = (count_reg == '0);
    assign rd.head  = slot_reg[rd_ptr_reg];

    // Store on push
    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= push_item;
    end

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/vdes_back.sv
// Back end: serial dose divider, store read-modify-write, result register
`default_nettype none
module vdes_back #(
    parameter int NUM_VOXELS = vdes_pkg::NUM_VOXELS_DEF,
    parameter int ACC_WIDTH  = vdes_pkg::ACC_WIDTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire vdes_pkg::q_rd_t                q_rd,
    output logic                                q_pop,
    output logic                                clr_busy,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [vdes_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tuser
);

    localparam int IDX_W  = $clog2(NUM_VOXELS);
    localparam int CNT_W  = $clog2(vdes_pkg::DIV_STEPS);
    localparam logic [ACC_WIDTH-1:0] ACC_MAX = {ACC_WIDTH{1'b1}};

    typedef enum logic [2:0] {B_CLR, B_IDLE, B_DIV, B_RD, B_WR, B_OUT} state_t;

    logic [ACC_WIDTH-1:0] dose_mem   [NUM_VOXELS];
    logic [ACC_WIDTH-1:0] energy_mem [NUM_VOXELS];

    state_t                      state_reg;
    logic [IDX_W-1:0]            clr_reg;
    vdes_pkg::item_t             item_reg;
    logic [vdes_pkg::PROD_W-1:0] num_reg;
    logic [vdes_pkg::DEN_W-1:0]  rem_reg;
    logic [ACC_WIDTH-1:0]        q_reg;
    logic                        ovf_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [ACC_WIDTH-1:0]        dose_rd_reg, energy_rd_reg;
    logic [vdes_pkg::OUT_IDX_W-1:0] out_idx_reg;
    logic                        out_hit_reg;
    logic [vdes_pkg::OUT_W-1:0]  out_dose_reg, out_energy_reg;

    logic [vdes_pkg::DEN_W:0]    rem2, rem_sub;
    logic                        ge;
    logic [ACC_WIDTH-1:0]        dsample, esample, dose_new, energy_new;
    logic [ACC_WIDTH:0]          dsum, esum;
    logic [63:0]                 e64, dose64, energy64, rd_dose64, rd_energy64;
    logic                        rd_en, we_d, we_e;
    logic [IDX_W-1:0]            wa, ra;

    assign clr_busy = (state_reg == B_CLR);
    assign q_pop    = (state_reg == B_IDLE) && !q_rd.empty;
    assign ra       = q_rd.head.idx[IDX_W-1:0];
    assign rd_en    = q_pop && q_rd.head.hit;

    // One restoring division step
    always_comb begin
        rem2    = {rem_reg, num_reg[vdes_pkg::PROD_W-1]};
        ge      = rem2 >= {1'b0, item_reg.den};
        rem_sub = ge ? rem2 - {1'b0, item_reg.den} : rem2;
    end

    // Samples and saturating sums
    always_comb begin
        if (item_reg.den == '0) dsample = (item_reg.prod != '0) ? ACC_MAX : '0;
        else                    dsample = ovf_reg ? ACC_MAX : q_reg;
        e64     = 64'(item_reg.prod[vdes_pkg::PROD_W-1:8]);
        esample = (e64 > 64'(ACC_MAX)) ? ACC_MAX : e64[ACC_WIDTH-1:0];
        dsum    = {1'b0, dose_rd_reg} + {1'b0, dsample};
        esum    = {1'b0, energy_rd_reg} + {1'b0, esample};
        dose_new   = dsum[ACC_WIDTH] ? ACC_MAX : dsum[ACC_WIDTH-1:0];
        energy_new = item_reg.esc ? (esum[ACC_WIDTH] ? ACC_MAX : esum[ACC_WIDTH-1:0])
                                  : energy_rd_reg;
        dose64      = 64'(dose_new);
        energy64    = 64'(energy_new);
        rd_dose64   = 64'(dose_rd_reg);
        rd_energy64 = 64'(energy_rd_reg);
    end

    // Store write port: clearing pass or update
    always_comb begin
        we_d = clr_busy || (state_reg == B_WR);
        we_e = clr_busy || ((state_reg == B_WR) && item_reg.esc);
        wa   = clr_busy ? clr_reg : item_reg.idx[IDX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (we_d) dose_mem[wa]   <= clr_busy ? '0 : dose_new;
        if (we_e) energy_mem[wa] <= clr_busy ? '0 : energy_new;
        if (rd_en) begin
            dose_rd_reg   <= dose_mem[ra];
            energy_rd_reg <= energy_mem[ra];
        end
    end

    assign m_tvalid = (state_reg == B_OUT);
    assign m_tuser  = out_hit_reg;
    assign m_tdata  = {out_energy_reg, out_dose_reg, out_idx_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_CLR;
            clr_reg     <= '0;
            out_hit_reg <= 1'b0;
        end else begin
            case (state_reg)
                B_CLR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == IDX_W'(NUM_VOXELS-1)) state_reg <= B_IDLE;
                end
                B_IDLE: begin
                    if (q_pop) begin
                        item_reg <= q_rd.head;
                        num_reg  <= q_rd.head.prod;
                        rem_reg  <= '0;
                        q_reg    <= '0;
                        ovf_reg  <= 1'b0;
                        cnt_reg  <= '0;
                        if (!q_rd.head.hit) begin
                            out_idx_reg    <= '0;
                            out_hit_reg    <= 1'b0;
                            out_dose_reg   <= '0;
                            out_energy_reg <= '0;
                            state_reg      <= B_OUT;
                        end else if (q_rd.head.is_read) begin
                            state_reg <= B_RD;
                        end else begin
                            state_reg <= B_DIV;
                        end
                    end
                end
                B_DIV: begin
                    num_reg <= {num_reg[vdes_pkg::PROD_W-2:0], 1'b0};
                    rem_reg <= rem_sub[vdes_pkg::DEN_W-1:0];
                    q_reg   <= {q_reg[ACC_WIDTH-2:0], ge};
                    ovf_reg <= ovf_reg | q_reg[ACC_WIDTH-1];
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(vdes_pkg::DIV_STEPS-1)) state_reg <= B_WR;
                end
                B_RD: begin
                    out_idx_reg    <= item_reg.idx[vdes_pkg::OUT_IDX_W-1:0];
                    out_hit_reg    <= 1'b1;
                    out_dose_reg   <= rd_dose64[vdes_pkg::OUT_W-1:0];
                    out_energy_reg <= rd_energy64[vdes_pkg::OUT_W-1:0];
                    state_reg      <= B_OUT;
                end
                B_WR: begin
                    out_idx_reg    <= item_reg.idx[vdes_pkg::OUT_IDX_W-1:0];
                    out_hit_reg    <= 1'b1;
                    out_dose_reg   <= dose64[vdes_pkg::OUT_W-1:0];
                    out_energy_reg <= energy64[vdes_pkg::OUT_W-1:0];
                    state_reg      <= B_OUT;
                end
                B_OUT: begin
                    if (m_tready) state_reg <= B_IDLE;
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/voxel_dose_energy_scoring.sv
// Voxel dose and energy scoring: top level with configuration registers
//
// Input stream s_*: one deposit or read per transfer. s_tuser is the function
// (0 deposit, 1 read). Result stream m_*: one result per input transfer, in order.
// Configuration: cfg_valid/cfg_index/cfg_data, always ready; write only while idle.
// The front holds a deposit through accept, three axis steps, index, multiply,
// check and push, and a read through accept and push, then hands the item to
// a two-entry queue, so it takes the next input while the back is still busy.
// The back runs a one-bit-per-cycle divider for the dose sample, 80 steps,
// then a read-modify-write of the dose and energy stores. With a ready receiver
// a deposit occupies the back through pop, 80 divide steps, write and output,
// a read through pop, read and output, and an outside-grid deposit through pop
// and output; the serial divider sets the sustained deposit rate.
// After reset the stores are cleared one entry per cycle (all NUM_VOXELS entries,
// 65536 by default); s_tready stays low until the pass ends.
// A stalled receiver holds the result in the output register; the back then
// stops popping, the queue fills and s_tready drops.
`default_nettype none
module voxel_dose_energy_scoring #(
    parameter int NUM_VOXELS = vdes_pkg::NUM_VOXELS_DEF,
    parameter int ACC_WIDTH  = vdes_pkg::ACC_WIDTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // pos_x[31:0] pos_y[63:32] pos_z[95:64] multiplicity[119:96]
    // energy_deposit[151:120] density[175:152] stopping_power_ratio[195:176]
    // read_index[211:196], zero pad to 216
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [vdes_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                           s_tuser,   // func
    // voxel_index[15:0] dose_value[63:16] energy_value[111:64]
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [vdes_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tuser,   // in_grid
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [vdes_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                    cfg_data
);

    vdes_pkg::cfg_t  cfg_reg;
    vdes_pkg::item_t q_item;
    vdes_pkg::q_rd_t q_rd;
    logic            q_push, q_full, q_pop, clr_busy;

    assign cfg_ready = 1'b1;

    // Hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.offset_x    <= '0;
            cfg_reg.offset_y    <= '0;
            cfg_reg.offset_z    <= '0;
            cfg_reg.inv_voxel_x <= 32'd65536;
            cfg_reg.inv_voxel_y <= 32'd65536;
            cfg_reg.inv_voxel_z <= 32'd65536;
            cfg_reg.grid_dims   <= '0;
            cfg_reg.score_mode  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                vdes_pkg::REG_OFFSET_X:    cfg_reg.offset_x    <= cfg_data;
                vdes_pkg::REG_OFFSET_Y:    cfg_reg.offset_y    <= cfg_data;
                vdes_pkg::REG_OFFSET_Z:    cfg_reg.offset_z    <= cfg_data;
                vdes_pkg::REG_INV_VOXEL_X: cfg_reg.inv_voxel_x <= cfg_data;
                vdes_pkg::REG_INV_VOXEL_Y: cfg_reg.inv_voxel_y <= cfg_data;
                vdes_pkg::REG_INV_VOXEL_Z: cfg_reg.inv_voxel_z <= cfg_data;
                vdes_pkg::REG_GRID_DIMS:   cfg_reg.grid_dims   <= cfg_data[29:0];
                vdes_pkg::REG_SCORE_MODE:  cfg_reg.score_mode  <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    vdes_front #(.NUM_VOXELS(NUM_VOXELS)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .clr_busy (clr_busy),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_push   (q_push),
        .q_item   (q_item),
        .q_full   (q_full)
    );

    vdes_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .rd        (q_rd)
    );

    vdes_back #(.NUM_VOXELS(NUM_VOXELS), .ACC_WIDTH(ACC_WIDTH)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_rd     (q_rd),
        .q_pop    (q_pop),
        .clr_busy (clr_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire

>>> rtl/core/vdes_checker.sv
// Port-level checks of the voxel scoring block and their binding
`default_nettype none
`include "voxel_dose_energy_scoring_assert.svh"
module vdes_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [vdes_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                           m_tuser
);

    // A result offered and not taken stays offered
    `VDES_ASSERT_NEXT(a_hold_result, !aresetn, m_tvalid && !m_tready, m_tvalid)

    // Reset leaves no result pending
    `VDES_ASSERT_NEXT(a_reset_quiet, 1'b0, !aresetn, !m_tvalid)

    // Store clearing begins at reset, so no input is taken right after it
    `VDES_ASSERT_NEXT(a_reset_clear, 1'b0, !aresetn, !s_tready)

    // A miss or an invalid read reports all zero fields
    `VDES_ASSERT_NOW(a_miss_zero, !aresetn, m_tvalid && !m_tuser, m_tdata == '0)

endmodule

bind voxel_dose_energy_scoring vdes_checker u_vdes_checker (.*);
`default_nettype wire
